// File: hdl/button_click_classifier_unit_defines.svh
// Assertion macros for the button click classifier.
// Included by the top level only; depends on nothing else.
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BCC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bcc_pkg.sv
// Shared types, codes and defaults for the button click classifier.
// No dependencies; imported by every module of the block.
package bcc_pkg;

    // Timer width default and configuration register width
    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CMP_W          = 33;
    localparam int COUNT_W        = 8;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] CLICK_RST    = 16'd400;
    localparam logic [CFG_W-1:0] PRESS_RST    = 16'd800;

    // Register indexes (word address)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_CLICK    = 2'd1;
    localparam logic [1:0] REG_PRESS    = 2'd2;

    // Phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_DOWN     = 3'd1;
    localparam logic [2:0] PH_UP       = 3'd2;
    localparam logic [2:0] PH_HELD     = 3'd3;
    localparam logic [2:0] PH_HELD_REL = 3'd4;

    // Event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_CLICK  = 3'd1;
    localparam logic [2:0] EV_DOUBLE = 3'd2;
    localparam logic [2:0] EV_MULTI  = 3'd3;
    localparam logic [2:0] EV_LONG   = 3'd4;

    localparam logic [COUNT_W-1:0] DOUBLE_COUNT = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;

    // Input beat
    typedef struct packed {
        logic pin_level;
        logic restart;
    } bcc_in_t;

    // Result beat
    typedef struct packed {
        logic [2:0]         event_res;
        logic [COUNT_W-1:0] click_count;
        logic               stable_level;
        logic [2:0]         phase;
    } bcc_out_t;

    // Configuration register set
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] click_ticks;
        logic [CFG_W-1:0] press_ticks;
    } bcc_cfg_t;

    // Classifier status toward the result register
    typedef struct packed {
        logic [2:0]         event_res;
        logic [COUNT_W-1:0] click_count;
        logic [2:0]         phase;
    } bcc_fsm_res_t;

endpackage

// File: hdl/bcc_debounce.sv
// Debouncer: candidate level, saturating stability timer, stable level.
// Depends on bcc_pkg.
module bcc_debounce import bcc_pkg::*; #(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick_en,
    input  logic             pin_level,
    input  logic [CFG_W-1:0] debounce_ticks,
    output logic             level_next
);

    logic                  cand_reg;
    logic                  deb_reg;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic                  deb_next;

    // Restart the timer on a change, else count up and saturate
    always_comb begin
        if (pin_level != cand_reg) begin
            timer_next = '0;
        end else if (timer_reg == {TIMER_BITS{1'b1}}) begin
            timer_next = timer_reg;
        end else begin
            timer_next = timer_reg + 1'b1;
        end
        if ({{(CMP_W-TIMER_BITS){1'b0}}, timer_next} >=
            {{(CMP_W-CFG_W){1'b0}}, debounce_ticks}) begin
            deb_next = pin_level;
        end else begin
            deb_next = deb_reg;
        end
    end

    assign level_next = deb_next;

    // Advance on each processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg  <= 1'b0;
            deb_reg   <= 1'b0;
            timer_reg <= '0;
        end else if (tick_en) begin
            cand_reg  <= pin_level;
            deb_reg   <= deb_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// File: hdl/bcc_fsm.sv
// Click classifier state machine: phases, saturating phase timer, click count.
// Depends on bcc_pkg.
module bcc_fsm import bcc_pkg::*; #(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         tick_en,
    input  logic         act,
    input  logic         restart,
    input  bcc_cfg_t     cfg,
    output bcc_fsm_res_t res
);

    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;
    logic [TIMER_BITS-1:0] ptimer_reg;
    logic [TIMER_BITS-1:0] ptimer_inc;
    logic [TIMER_BITS-1:0] ptimer_next;
    logic [COUNT_W-1:0]    clicks_reg;
    logic [COUNT_W-1:0]    clicks_next;
    logic [2:0]            ev;
    logic [COUNT_W-1:0]    count_out;
    logic [CMP_W-1:0]      ptimer_ext;
    logic                  over_click;
    logic                  over_press;

    // Saturating phase timer and strict bound compares
    always_comb begin
        if (ptimer_reg == {TIMER_BITS{1'b1}}) begin
            ptimer_inc = ptimer_reg;
        end else begin
            ptimer_inc = ptimer_reg + 1'b1;
        end
        ptimer_ext = {{(CMP_W-TIMER_BITS){1'b0}}, ptimer_inc};
        over_click = ptimer_ext > {{(CMP_W-CFG_W){1'b0}}, cfg.click_ticks};
        over_press = ptimer_ext > {{(CMP_W-CFG_W){1'b0}}, cfg.press_ticks};
    end

    // Phase transitions; any phase change clears the timer
    always_comb begin
        phase_next  = phase_reg;
        clicks_next = clicks_reg;
        ev          = EV_NONE;
        count_out   = '0;
        if (restart) begin
            phase_next  = PH_IDLE;
            clicks_next = '0;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (act) begin
                        phase_next  = PH_DOWN;
                        clicks_next = '0;
                    end
                end
                PH_DOWN: begin
                    if (!act) begin
                        if (clicks_reg != COUNT_MAX) begin
                            clicks_next = clicks_reg + 1'b1;
                        end
                        phase_next = PH_UP;
                    end else if (over_press) begin
                        ev          = EV_LONG;
                        clicks_next = '0;
                        phase_next  = PH_HELD;
                    end
                end
                PH_UP: begin
                    if (act) begin
                        phase_next = PH_DOWN;
                    end else if (over_click) begin
                        if (clicks_reg == 8'd1) begin
                            ev = EV_CLICK;
                        end else if (clicks_reg == DOUBLE_COUNT) begin
                            ev = EV_DOUBLE;
                        end else if (clicks_reg > DOUBLE_COUNT) begin
                            ev = EV_MULTI;
                        end
                        if (clicks_reg != '0) begin
                            count_out = clicks_reg;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                PH_HELD: begin
                    if (!act) begin
                        phase_next = PH_HELD_REL;
                    end
                end
                PH_HELD_REL: begin
                    if (!act && over_click) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        // Restart always clears the timer, even when already idle
        if (restart || (phase_next != phase_reg)) begin
            ptimer_next = '0;
        end else begin
            ptimer_next = ptimer_inc;
        end
    end

    assign res.event_res   = ev;
    assign res.click_count = count_out;
    assign res.phase       = phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            ptimer_reg <= '0;
            clicks_reg <= '0;
        end else if (tick_en) begin
            phase_reg  <= phase_next;
            ptimer_reg <= ptimer_next;
            clicks_reg <= clicks_next;
        end
    end

endmodule

// File: hdl/button_click_classifier_unit.sv
// Top level of the button click classifier: input register, APB registers,
// debouncer, classifier and result register. Depends on bcc_pkg and the defines header.
//
//   channel | ports                       | beat
//   input   | s_valid s_ready s_data      | one tick: pin_level, restart
//   result  | m_valid m_ready m_data      | event_res, click_count, stable_level, phase
//   config  | psel penable pwrite paddr.. | APB write/read, pready tied high
//
// One tick per clock unless the result channel stalls: a beat waits in the input register, then the
// debouncer and classifier update and the result register loads together when it advances.
// Throughput is one beat per cycle while the result channel is not stalled.
// Reset (synchronous, aresetn low) clears the valid flags, debouncer and classifier state and loads register defaults.
// A stalled result holds the input register; s_ready drops only when both are full.
`include "button_click_classifier_unit_defines.svh"
module button_click_classifier_unit import bcc_pkg::*; #(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bcc_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bcc_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    bcc_cfg_t     cfg_reg;
    bcc_in_t      in_reg;
    logic         in_valid_reg;
    bcc_out_t     out_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         s_accept;
    logic         level_next;
    bcc_fsm_res_t fsm_res;
    logic         cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RST;
            cfg_reg.click_ticks    <= CLICK_RST;
            cfg_reg.press_ticks    <= PRESS_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_DEBOUNCE: cfg_reg.debounce_ticks <= pwdata[CFG_W-1:0];
                REG_CLICK:    cfg_reg.click_ticks    <= pwdata[CFG_W-1:0];
                REG_PRESS:    cfg_reg.press_ticks    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEBOUNCE: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.debounce_ticks};
            REG_CLICK:    prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.click_ticks};
            REG_PRESS:    prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.press_ticks};
            default:      prdata = '0;
        endcase
    end

    // Handshake: advance the input beat when the result register is empty or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
    end

    bcc_debounce #(
        .TIMER_BITS(TIMER_BITS)
    ) u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick_en        (advance),
        .pin_level      (in_reg.pin_level),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .level_next     (level_next)
    );

    bcc_fsm #(
        .TIMER_BITS(TIMER_BITS)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance),
        .act     (level_next),
        .restart (in_reg.restart),
        .cfg     (cfg_reg),
        .res     (fsm_res)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg.event_res    <= fsm_res.event_res;
            out_reg.click_count  <= fsm_res.click_count;
            out_reg.stable_level <= level_next;
            out_reg.phase        <= fsm_res.phase;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Checks on the classifier and pipeline control
    `BCC_ASSERT_SAME(a_long_no_count, aclk, aresetn, m_valid && (m_data.event_res == EV_LONG), m_data.click_count == '0, "long press carries a click count")
    `BCC_ASSERT_SAME(a_click_idle, aclk, aresetn, m_valid && ((m_data.event_res == EV_CLICK) || (m_data.event_res == EV_DOUBLE) || (m_data.event_res == EV_MULTI)), (m_data.phase == PH_IDLE) && (m_data.click_count != '0), "closed sequence not idle or empty")
    `BCC_ASSERT_SAME(a_none_no_count, aclk, aresetn, m_valid && (m_data.event_res == EV_NONE), m_data.click_count == '0, "count without event")
    `BCC_ASSERT_NEXT(a_stall_full, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready, in_valid_reg && out_valid_reg, "pipeline lost a beat under stall")

endmodule

// File: tb/sv/tb_button_click_classifier_unit.sv
// Self-checking testbench for button_click_classifier_unit: ticks go in on the input
// channel, a predictor in a scoreboard class computes every result beat it expects.
// Depends on bcc_pkg and the RTL of the block only.
module tb_button_click_classifier_unit;
    import bcc_pkg::*;

    localparam int TB_TIMER_W  = TIMER_BITS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int SHOWN_MAX   = 10;

    // Predicts the classifier tick by tick and checks the result beats in order
    class click_scoreboard;
        logic [CFG_W-1:0]      debounce_lim;
        logic [CFG_W-1:0]      click_lim;
        logic [CFG_W-1:0]      press_lim;
        logic                  candidate;
        logic                  level;
        logic [TB_TIMER_W-1:0] stable_t;
        logic [TB_TIMER_W-1:0] phase_t;
        logic [2:0]            phase;
        logic [COUNT_W-1:0]    clicks;
        bcc_out_t              due_results[$];
        int                    mismatches;

        function new();
            debounce_lim = DEBOUNCE_RST;
            click_lim    = CLICK_RST;
            press_lim    = PRESS_RST;
            candidate    = 1'b0;
            level        = 1'b0;
            stable_t     = '0;
            phase_t      = '0;
            phase        = PH_IDLE;
            clicks       = '0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DEBOUNCE: debounce_lim = val;
                REG_CLICK:    click_lim    = val;
                REG_PRESS:    press_lim    = val;
                default: ;
            endcase
        endfunction

        // Saturating tick counter
        function logic [TB_TIMER_W-1:0] bump(logic [TB_TIMER_W-1:0] t);
            return (t == '1) ? t : t + 1'b1;
        endfunction

        function void enter(logic [2:0] next_phase);
            phase   = next_phase;
            phase_t = '0;
        endfunction

        function bcc_out_t classify_tick(bcc_in_t beat);
            bcc_out_t r;
            logic     pressed;
            r.event_res   = EV_NONE;
            r.click_count = '0;

            // Debounce: a new raw level restarts the stability count
            if (beat.pin_level != candidate) begin
                candidate = beat.pin_level;
                stable_t  = '0;
            end else begin
                stable_t = bump(stable_t);
            end
            if (stable_t >= debounce_lim) begin
                level = candidate;
            end
            pressed = level;
            phase_t = bump(phase_t);

            if (beat.restart) begin
                enter(PH_IDLE);
                clicks = '0;
            end else begin
                case (phase)
                    PH_IDLE: begin
                        if (pressed) begin
                            enter(PH_DOWN);
                            clicks = '0;
                        end
                    end
                    PH_DOWN: begin
                        if (!pressed) begin
                            if (clicks != COUNT_MAX) begin
                                clicks = clicks + 1'b1;
                            end
                            enter(PH_UP);
                        end else if (phase_t > press_lim) begin
                            r.event_res = EV_LONG;
                            clicks      = '0;
                            enter(PH_HELD);
                        end
                    end
                    PH_UP: begin
                        if (pressed) begin
                            enter(PH_DOWN);
                        end else if (phase_t > click_lim) begin
                            // Close the sequence and classify it by its click count
                            if (clicks == 8'd1) begin
                                r.event_res = EV_CLICK;
                            end else if (clicks == DOUBLE_COUNT) begin
                                r.event_res = EV_DOUBLE;
                            end else if (clicks > DOUBLE_COUNT) begin
                                r.event_res = EV_MULTI;
                            end
                            if (r.event_res != EV_NONE) begin
                                r.click_count = clicks;
                            end
                            enter(PH_IDLE);
                        end
                    end
                    PH_HELD: begin
                        if (!pressed) begin
                            enter(PH_HELD_REL);
                        end
                    end
                    PH_HELD_REL: begin
                        if (!pressed && phase_t > click_lim) begin
                            enter(PH_IDLE);
                        end
                    end
                    default: enter(PH_IDLE);
                endcase
            end

            r.stable_level = level;
            r.phase        = phase;
            return r;
        endfunction

        function void note_tick(bcc_in_t beat);
            due_results.push_back(classify_tick(beat));
        endfunction

        function void check_result(bcc_out_t got);
            bcc_out_t want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MAX) begin
                    $display("unexpected result beat: event %0d count %0d level %0d phase %0d",
                             got.event_res, got.click_count, got.stable_level, got.phase);
                end
                return;
            end
            want = due_results.pop_front();
            if (got.event_res !== want.event_res || got.click_count !== want.click_count ||
                got.stable_level !== want.stable_level || got.phase !== want.phase) begin
                mismatches++;
                if (mismatches <= SHOWN_MAX) begin
                    $display("result mismatch: event %0d/%0d count %0d/%0d level %0d/%0d %s",
                             want.event_res, got.event_res, want.click_count, got.click_count,
                             want.stable_level, got.stable_level,
                             $sformatf("phase %0d/%0d (expected/actual)", want.phase, got.phase));
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    bcc_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    bcc_out_t          m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    click_scoreboard sb = new();
    bit idling_on   = 1'b1;
    bit restarts_on = 1'b1;
    int ticks_sent  = 0;
    int quiet_cycles = 0;
    int deb_cfg;
    int click_cfg;
    int press_cfg;

    button_click_classifier_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel in random bursts
    initial begin
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold == 0 && idling_on && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 19);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check result beats; count cycles with no beat moving on either channel
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    // Send one tick, with an occasional random idle burst ahead of it
    task automatic send_tick(input logic pin, input logic rst);
        bcc_in_t beat;
        int      gap;
        beat.pin_level = pin;
        beat.restart   = rst;
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(beat);
        ticks_sent++;
    endtask

    // Hold one raw level for n ticks, with a rare restart mixed in
    task automatic send_level(input logic pin, input int n);
        repeat (n) send_tick(pin, restarts_on && $urandom_range(0, 63) == 0);
    endtask

    // 0/1 = raw level, r/R = restart with level low/high
    task automatic send_pattern(input string pat);
        for (int i = 0; i < pat.len(); i++) begin
            case (pat[i])
                "0": send_tick(1'b0, 1'b0);
                "1": send_tick(1'b1, 1'b0);
                "r": send_tick(1'b0, 1'b1);
                default: send_tick(1'b1, 1'b1);
            endcase
        end
    endtask

    // Drop valid and wait until every expected result beat has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(CFG_W'(val));
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, CFG_W'(val));
    endtask

    task automatic set_config(input int deb, input int clk_lim, input int prs);
        drain();
        deb_cfg   = deb;
        click_cfg = clk_lim;
        press_cfg = prs;
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_CLICK, clk_lim);
        write_reg(REG_PRESS, prs);
    endtask

    // Mostly click sequences and long presses with random timing, plus noise
    task automatic click_session(input int budget, input bit noise_only);
        int first;
        int kind;
        first = ticks_sent;
        while (ticks_sent - first < budget) begin
            kind = noise_only ? 9 : $urandom_range(0, 9);
            if (kind < 7) begin
                repeat ($urandom_range(1, 5)) begin
                    // Bounce shorter than the debounce window
                    if (deb_cfg > 0 && $urandom_range(0, 2) == 0) begin
                        send_level(1'b1, $urandom_range(1, deb_cfg));
                        send_level(1'b0, 1);
                    end
                    send_level(1'b1, $urandom_range(deb_cfg + 1, deb_cfg + press_cfg + 1));
                    send_level(1'b0, $urandom_range(deb_cfg + 1, deb_cfg + click_cfg + 1));
                end
                send_level(1'b0, deb_cfg + click_cfg + 2);
            end else if (kind < 8) begin
                send_level(1'b1, deb_cfg + press_cfg + 2 + $urandom_range(0, 4));
                send_level(1'b0, deb_cfg + click_cfg + 2 + $urandom_range(0, 2));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults: the long debounce keeps these presses out
        send_pattern("1r");

        // Directed: single, double, multi click, long press, restart
        set_config(0, 0, 2);
        send_pattern("100");
        send_pattern("10100");
        send_pattern("1010100");
        send_pattern("111100");
        send_pattern("1R");

        // Zero thresholds, then two small random settings
        set_config(0, 0, 0);
        click_session(60, 1'b0);
        repeat (2) begin
            set_config($urandom_range(0, 3), $urandom_range(0, 10), $urandom_range(0, 16));
            click_session(120, 1'b0);
        end

        // Largest thresholds: nothing can settle, drive noise only
        set_config(32'hFFFF, 32'hFFFF, 32'hFFFF);
        click_session(40, 1'b1);

        // Rapid clicks past the count limit, then close the sequence
        set_config(0, 2, 32'hFFFF);
        restarts_on = 1'b0;
        repeat (258 + $urandom_range(0, 4)) begin
            send_level(1'b1, 1);
            send_level(1'b0, 1);
        end
        send_level(1'b0, 4);
        restarts_on = 1'b1;

        // Last stretch at full rate on both channels
        set_config($urandom_range(0, 3), $urandom_range(0, 10), $urandom_range(0, 16));
        idling_on = 1'b0;
        click_session(100, 1'b0);

        drain();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
